FILE: rtl/core/vertex_colour_to_argb8_defines.svh
// Assertion macros used by the checker file.
`ifndef VERTEX_COLOUR_TO_ARGB8_DEFINES_SVH
`define VERTEX_COLOUR_TO_ARGB8_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define VC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define VC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/vc_pkg.sv
// ----------------------------------------------------------------------------
// vc_pkg
// Shared constants and types for the vertex colour converter.
// ----------------------------------------------------------------------------
package vc_pkg;
  localparam logic [2:0] TYPE_DOUBLE = 3'd0;
  localparam logic [2:0] TYPE_FLOAT  = 3'd1;
  localparam logic [2:0] TYPE_BYTE   = 3'd2;
  localparam logic [2:0] TYPE_U16    = 3'd3;
  localparam logic [2:0] TYPE_U32    = 3'd4;

  localparam logic [1:0] LAYOUT_RGB  = 2'd0;
  localparam logic [1:0] LAYOUT_RGBA = 2'd1;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_TYPE   = 2'd1;
  localparam logic [1:0] REG_LAYOUT = 2'd2;

  // Per-lane kind after decode: a direct 8-bit value, a float, or a 16- or
  // 32-bit integer that still needs the scale and divide steps.
  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_FLOAT  = 2'd1,
    K_U16    = 2'd2,
    K_U32    = 2'd3
  } kind_e;

  typedef struct packed {
    logic enabled;
    logic three;
    logic lane_order;
  } ctl_t;
endpackage

FILE: rtl/core/vc_if.sv
// ----------------------------------------------------------------------------
// vc_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface vc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/vc_decode.sv
// ----------------------------------------------------------------------------
// vc_decode
// Stage 1 for one component: narrow the raw bits to a float or an integer.
// ----------------------------------------------------------------------------
module vc_decode (
  input  logic [63:0]       raw_i,
  input  logic [2:0]        type_i,
  output vc_pkg::kind_e     kind_o,
  output logic [31:0]       val_o
);
  logic        sgn;
  logic [10:0] de;
  logic [51:0] dm;
  logic [31:0] fl;
  // Double -> single, only the outcome for the 0..255 mapping matters.
  always_comb begin
    sgn = raw_i[63];
    de  = raw_i[62:52];
    dm  = raw_i[51:0];
    fl  = 32'd0;
    if (de == 11'h7FF) begin
      fl = (dm != 52'd0) ? 32'h7FC00000 : {sgn, 31'h40000000};
    end else if (de >= 11'd1024) begin
      fl = {sgn, 31'h40000000};
    end else if (de < 11'd870) begin
      fl = {sgn, 31'd0};
    end else begin
      // Tiny values round toward zero; any nonzero positive tiny value
      // still gives a channel of 0, so this is exact for our purpose.
      if (de < 11'd897) fl = {sgn, 31'd0};
      else begin
        fl = {sgn, 8'(de - 11'd896), dm[51:29]} + {31'd0,
             dm[28] & (dm[29] | (dm[27:0] != 28'd0))};
      end
    end
  end

  always_comb begin
    case (type_i)
      vc_pkg::TYPE_DOUBLE: begin kind_o = vc_pkg::K_FLOAT; val_o = fl; end
      vc_pkg::TYPE_BYTE:   begin kind_o = vc_pkg::K_DIRECT; val_o = {24'd0, raw_i[7:0]}; end
      vc_pkg::TYPE_U16:    begin kind_o = vc_pkg::K_U16; val_o = {16'd0, raw_i[15:0]}; end
      vc_pkg::TYPE_U32:    begin kind_o = vc_pkg::K_U32; val_o = raw_i[31:0]; end
      default:             begin kind_o = vc_pkg::K_FLOAT; val_o = raw_i[31:0]; end
    endcase
  end
endmodule

FILE: rtl/core/vc_scale.sv
// ----------------------------------------------------------------------------
// vc_scale
// Stage 2 for one component: form x*255 (integer), the float channel, or pass a byte.
// ----------------------------------------------------------------------------
module vc_scale (
  input  vc_pkg::kind_e kind_i,
  input  logic [31:0]   val_i,
  output logic [39:0]   prod_o
);
  logic [7:0]  e;
  logic [23:0] m;
  logic [31:0] ip;
  logic [8:0]  ch;
  // Float: channel = trunc(round_f32(f*255)) clamped. f*255 exact in 32 bits
  // of mantissa product; round to 24 bits then truncate to integer.
  logic [31:0] p;
  logic [4:0]  msb;
  logic [31:0] rnd;
  logic [7:0]  sh;
  always_comb begin
    e   = val_i[30:23];
    m   = {1'b1, val_i[22:0]};
    p   = {m, 8'd0} - {8'd0, m};   // m*255, below 2^32
    msb = p[31] ? 5'd31 : 5'd30;
    // Keep 24 significant bits, round to nearest even.
    if (p[31]) rnd = ({p[31:8], 8'd0}) +
                     ((p[7] && (p[8] || p[6:0] != 7'd0)) ? 32'd256 : 32'd0);
    else       rnd = ({1'b0, p[30:7], 7'd0}) +
                     ((p[6] && (p[7] || p[5:0] != 6'd0)) ? 32'd128 : 32'd0);
    // value = rnd * 2^(e-127-23-8+... ) : integer part = rnd >> (31+150-e-? )
    // f = m*2^(e-150); s = p*2^(e-150); int = rnd >> (150-e)
    sh  = 8'd150 - e;
    ch  = 9'd0;
    ip  = 32'd0;
    if (e == 8'hFF) ch = (val_i[22:0] != 23'd0 || val_i[31]) ? 9'd0 : 9'd255;
    else if (val_i[31] || e < 8'd119) ch = 9'd0;
    else if (e > 8'd134) ch = 9'd255;
    else begin
      ip = rnd >> sh;
      ch = (ip >= 32'd255) ? 9'd255 : {1'b0, ip[7:0]};
    end
    if (msb == 5'd0) ch = 9'd0;
    case (kind_i)
      vc_pkg::K_FLOAT:  prod_o = {31'd0, ch};
      vc_pkg::K_DIRECT: prod_o = {32'd0, val_i[7:0]};
      default:          prod_o = {val_i, 8'd0} - {8'd0, val_i};
    endcase
  end
endmodule

FILE: rtl/core/vc_divide.sv
// ----------------------------------------------------------------------------
// vc_divide
// Stage 3 for one component: exact floor(x*255/max) by reciprocal trick.
// ----------------------------------------------------------------------------
module vc_divide (
  input  vc_pkg::kind_e kind_i,
  input  logic [39:0]   prod_i,
  output logic [7:0]    chan_o
);
  logic [40:0] q16;
  logic [40:0] q32;
  logic [40:0] t;
  always_comb begin
    // floor(y/(2^n-1)) = (y + (y>>n) + 1) >> n for y < (2^n-1)*2^n.
    t   = {1'b0, prod_i} + 41'(prod_i >> 16) + 41'd1;
    q16 = t >> 16;
    t   = {1'b0, prod_i} + 41'(prod_i >> 32) + 41'd1;
    q32 = t >> 32;
    case (kind_i)
      vc_pkg::K_U16: chan_o = q16[7:0];
      vc_pkg::K_U32: chan_o = q32[7:0];
      default:       chan_o = prod_i[7:0];
    endcase
  end
endmodule

FILE: rtl/core/vertex_colour_to_argb8.sv
// Three compute stages plus the output register; throughput: one word per
// cycle while the output is not stalled.
// Each stage holds while its successor is full and stalled, so a stall
// propagates backward without loss. Reset clears all valid bits and sets
// the configuration to disabled, float type, four-component layout.
// ----------------------------------------------------------------------------
// vertex_colour_to_argb8
// Converts one vertex colour to a packed ARGB8 word in a pipeline.
// ----------------------------------------------------------------------------
module vertex_colour_to_argb8 #(
  parameter int unsigned RED_LANE   = 2,
  parameter int unsigned GREEN_LANE = 1,
  parameter int unsigned BLUE_LANE  = 0,
  parameter int unsigned ALPHA_LANE = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  vc_if.sink          in_i,
  vc_if.source        out_o
);
  logic       en_q;
  logic [2:0] type_q;
  logic [1:0] layout_q;

  // Configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      type_q   <= vc_pkg::TYPE_FLOAT;
      layout_q <= vc_pkg::LAYOUT_RGBA;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vc_pkg::REG_ENABLE: en_q     <= cfg_data_i[0];
        vc_pkg::REG_TYPE:   type_q   <= cfg_data_i;
        vc_pkg::REG_LAYOUT: layout_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and advance enables (stage k advances when empty or
  // when its successor moves).
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv1, adv2, adv3, advo;
  assign advo = !vo_q || out_o.ready;
  assign adv3 = !v3_q || advo;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_i.ready = adv1;

  vc_pkg::ctl_t ctl_in, ctl1_q, ctl2_q, ctl3_q;
  assign ctl_in = '{enabled: en_q, three: (layout_q == vc_pkg::LAYOUT_RGB),
                    lane_order: layout_q[1]};

  logic [63:0] raw [4];
  assign raw[0] = in_i.data[63:0];
  assign raw[1] = in_i.data[127:64];
  assign raw[2] = in_i.data[191:128];
  assign raw[3] = in_i.data[255:192];

  vc_pkg::kind_e kind_d [4];
  vc_pkg::kind_e kind1_q [4];
  vc_pkg::kind_e kind2_q [4];
  logic [31:0]   val_d [4];
  logic [31:0]   val1_q [4];
  logic [39:0]   prod_d [4];
  logic [39:0]   prod2_q [4];
  logic [7:0]    chan_d [4];
  logic [7:0]    chan3_q [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    vc_decode u_dec (.raw_i(raw[g]), .type_i(type_q), .kind_o(kind_d[g]), .val_o(val_d[g]));
    vc_scale u_scl (.kind_i(kind1_q[g]), .val_i(val1_q[g]), .prod_o(prod_d[g]));
    vc_divide u_div (.kind_i(kind2_q[g]), .prod_i(prod2_q[g]), .chan_o(chan_d[g]));
    always_ff @(posedge clk_i) begin
      if (adv1) begin
        kind1_q[g] <= kind_d[g];
        val1_q[g]  <= val_d[g];
      end
      if (adv2) begin
        kind2_q[g] <= kind1_q[g];
        prod2_q[g] <= prod_d[g];
      end
      if (adv3) chan3_q[g] <= chan_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (advo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) ctl1_q <= ctl_in;
    if (adv2) ctl2_q <= ctl1_q;
    if (adv3) ctl3_q <= ctl2_q;
  end

  // Pack channels: red, green, blue, alpha written in that order.
  logic [7:0]  alpha;
  logic [31:0] word_d, word_q;
  always_comb begin
    alpha  = ctl3_q.three ? 8'hFF : chan3_q[3];
    word_d = 32'd0;
    if (!ctl3_q.enabled) begin
      word_d = 32'hFFFF_FFFF;
    end else if (ctl3_q.lane_order) begin
      word_d = {alpha, chan3_q[2], chan3_q[1], chan3_q[0]};
    end else begin
      word_d[8*(RED_LANE % 4) +: 8]   = chan3_q[0];
      word_d[8*(GREEN_LANE % 4) +: 8] = chan3_q[1];
      word_d[8*(BLUE_LANE % 4) +: 8]  = chan3_q[2];
      word_d[8*(ALPHA_LANE % 4) +: 8] = alpha;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advo) word_q <= word_d;
  end

  assign out_o.valid = vo_q;
  assign out_o.data  = word_q;
endmodule

FILE: rtl/core/vc_checker.sv
// ----------------------------------------------------------------------------
// vc_checker
// Port-level checks for the vertex colour converter.
// ----------------------------------------------------------------------------
`include "vertex_colour_to_argb8_defines.svh"
module vc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data
);
  `VC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `VC_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid, in_ready)
  `VC_ASSERT_IMP(a_ready_out, clk_i, rst_ni, out_ready, in_ready)
endmodule

bind vertex_colour_to_argb8 vc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

FILE: tb/sv/tb_vertex_colour_to_argb8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_colour_to_argb8
// Self-checking bench for the vertex colour to ARGB8 converter: drives raw
// colour words through the valid/ready channels under random idling and
// compares every packed output word against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_vertex_colour_to_argb8;
  localparam int unsigned RED_LN   = 2;
  localparam int unsigned GREEN_LN = 1;
  localparam int unsigned BLUE_LN  = 0;
  localparam int unsigned ALPHA_LN = 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PER_PHASE = 46;
  // Layout code 2 (and unused code 3) places components in lane order.
  localparam logic [1:0] LAYOUT_LANES = 2'd2;

  // One colour as it arrives from vertex fetch: raw component bits, first
  // component in the low 64 bits.
  typedef struct packed {
    logic [63:0] comp_d;
    logic [63:0] comp_c;
    logic [63:0] comp_b;
    logic [63:0] comp_a;
  } colour_in_t;

  // --------------------------------------------------------------------------
  // Expected-colour store: holds the converter settings, predicts the packed
  // word of each accepted colour and matches outputs in order.
  // --------------------------------------------------------------------------
  class argb_scoreboard;
    bit          enabled;
    logic [2:0]  comp_type;
    logic [1:0]  layout;
    logic [31:0] expected_words[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      enabled = 1'b0;
      comp_type = vc_pkg::TYPE_FLOAT;
      layout = vc_pkg::LAYOUT_RGBA;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [2:0] val);
      case (idx)
        vc_pkg::REG_ENABLE: enabled = val[0];
        vc_pkg::REG_TYPE:   comp_type = val;
        vc_pkg::REG_LAYOUT: layout = val[1:0];
        default: ;
      endcase
    endfunction

    // Shift right with round-to-nearest-even.
    static function logic [63:0] shift_rne(logic [63:0] v, int sh);
      logic [63:0] t, rem, half;
      if (sh == 0) return v;
      t = v >> sh;
      rem = v & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && t[0])) t = t + 1;
      return t;
    endfunction

    // Single-precision value times 255 (rounded to single), clamped, truncated.
    static function logic [7:0] chan_of_float(logic [31:0] w);
      logic [7:0]  ex;
      logic [63:0] p, q, ip;
      int          e, len, sh, e2;
      ex = w[30:23];
      if (ex == 8'hFF) return (w[22:0] != 0 || w[31]) ? 8'd0 : 8'd255;
      if (w[31] || w[30:0] == 0) return 8'd0;
      p = (ex == 0) ? {41'd0, w[22:0]} : {40'd0, 1'b1, w[22:0]};
      e = (ex == 0) ? 1 : int'(ex);
      p = p * 64'd255;
      len = 0;
      for (int i = 0; i < 64; i++) if (p[i]) len = i + 1;
      sh = (len > 24) ? len - 24 : 0;
      q = shift_rne(p, sh);
      e2 = sh + e - 150;
      if (e2 >= 0) return 8'd255;
      ip = (-e2 >= 64) ? 64'd0 : (q >> (-e2));
      return (ip >= 255) ? 8'd255 : ip[7:0];
    endfunction

    // Double: clamp, round to single, then the float path.
    static function logic [7:0] chan_of_double(logic [63:0] d);
      logic [10:0] ex;
      logic [63:0] q;
      int          fe;
      ex = d[62:52];
      if (ex == 11'h7FF) return (d[51:0] != 0 || d[63]) ? 8'd0 : 8'd255;
      if (d[63] || ex == 0) return 8'd0;
      if (ex > 11'd1024 || (ex == 11'd1024 && d[51:0] != 0)) return 8'd255;
      fe = int'(ex) - 1023 + 127;
      // Anything that lands subnormal in single scales to below one.
      if (fe < 1) return 8'd0;
      q = shift_rne({11'd0, 1'b1, d[51:0]}, 29);
      if (q[24]) begin
        q = q >> 1;
        fe++;
      end
      return chan_of_float({1'b0, fe[7:0], q[22:0]});
    endfunction

    function logic [7:0] chan_of_raw(logic [63:0] raw);
      logic [63:0] t;
      case (comp_type)
        vc_pkg::TYPE_DOUBLE: return chan_of_double(raw);
        vc_pkg::TYPE_BYTE:   return raw[7:0];
        vc_pkg::TYPE_U16: begin
          t = ({48'd0, raw[15:0]} * 64'd255) / 64'd65535;
          return t[7:0];
        end
        vc_pkg::TYPE_U32: begin
          t = ({32'd0, raw[31:0]} * 64'd255) / 64'hFFFF_FFFF;
          return t[7:0];
        end
        default: return chan_of_float(raw[31:0]);
      endcase
    endfunction

    function void note_colour(colour_in_t c);
      logic [7:0]  r, g, b, a;
      logic [31:0] w;
      if (!enabled) begin
        expected_words.push_back(32'hFFFF_FFFF);
        return;
      end
      r = chan_of_raw(c.comp_a);
      g = chan_of_raw(c.comp_b);
      b = chan_of_raw(c.comp_c);
      a = (layout == vc_pkg::LAYOUT_RGB) ? 8'd255 : chan_of_raw(c.comp_d);
      if (layout >= LAYOUT_LANES) begin
        w = {a, b, g, r};
      end else begin
        // Later channels overwrite earlier ones in a shared lane.
        w = 32'd0;
        w[8*(RED_LN & 3) +: 8]   = r;
        w[8*(GREEN_LN & 3) +: 8] = g;
        w[8*(BLUE_LN & 3) +: 8]  = b;
        w[8*(ALPHA_LN & 3) +: 8] = a;
      end
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] exp_w;
      checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got !== exp_w) begin
        $display("%0t: packed_colour mismatch, expected %h actual %h", $time, exp_w, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [2:0]  cfg_data_i;
  int unsigned cycles;
  bit          no_idle;
  int unsigned sent;

  argb_scoreboard sb;

  vc_if #(.payload_t(colour_in_t))  colour_ch ();
  vc_if #(.payload_t(logic [31:0])) argb_ch ();

  vertex_colour_to_argb8 #(
    .RED_LANE  (RED_LN),
    .GREEN_LANE(GREEN_LN),
    .BLUE_LANE (BLUE_LN),
    .ALPHA_LANE(ALPHA_LN)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (colour_ch),
    .out_o      (argb_ch)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: hold ready low for a random stall before each word, unless
  // the phase runs without idling; check each word as it is taken.
  initial begin
    int unsigned stall;
    argb_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        argb_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      argb_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!argb_ch.valid);
      sb.check_word(argb_ch.data);
    end
  end

  // Drive one colour word: optional gap with valid low, then hold it until
  // the block takes it. Valid stays high between back-to-back words.
  task automatic send_colour(colour_in_t c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      colour_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    colour_ch.valid <= 1'b1;
    colour_ch.data  <= c;
    do @(posedge clk_i); while (!colour_ch.ready);
    sb.note_colour(c);
    sent++;
  endtask

  // Drain the pipeline, then write all three registers back to back.
  task automatic write_settings(logic en, logic [2:0] ty, logic [1:0] lay);
    colour_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= vc_pkg::REG_ENABLE;
    cfg_data_i <= {2'b00, en};
    @(posedge clk_i);
    cfg_index_i <= vc_pkg::REG_TYPE;
    cfg_data_i <= ty;
    @(posedge clk_i);
    cfg_index_i <= vc_pkg::REG_LAYOUT;
    cfg_data_i <= {1'b0, lay};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(vc_pkg::REG_ENABLE, {2'b00, en});
    sb.set_reg(vc_pkg::REG_TYPE, ty);
    sb.set_reg(vc_pkg::REG_LAYOUT, {1'b0, lay});
  endtask

  // Edge values per component type: zero, one, NaN, infinities, negatives,
  // saturation points and the largest value just under one.
  function automatic logic [63:0] edge_value(logic [2:0] ty, int k);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    case (ty)
      vc_pkg::TYPE_DOUBLE: begin
        case (k % 10)
          0: return 64'h0000_0000_0000_0000;
          1: return 64'h3FF0_0000_0000_0000;
          2: return 64'h7FF8_0000_0000_0001;
          3: return 64'h7FF0_0000_0000_0000;
          4: return 64'hFFF0_0000_0000_0000;
          5: return 64'hBFF0_0000_0000_0000;
          6: return 64'h7E37_E43C_8800_759C;
          7: return 64'h0000_0000_0000_0001;
          8: return 64'h3FEF_FFFF_FFFF_FFFF;
          default: return 64'h4000_0000_0000_0000;
        endcase
      end
      vc_pkg::TYPE_U16: begin
        case (k % 5)
          0: return {junk[63:16], 16'h0000};
          1: return {junk[63:16], 16'hFFFF};
          2: return {junk[63:16], 16'h8000};
          3: return {junk[63:16], 16'hFFFE};
          default: return {junk[63:16], 16'h0101};
        endcase
      end
      vc_pkg::TYPE_U32: begin
        case (k % 5)
          0: return {junk[63:32], 32'h0000_0000};
          1: return {junk[63:32], 32'hFFFF_FFFF};
          2: return {junk[63:32], 32'h8000_0000};
          3: return {junk[63:32], 32'hFFFF_FFFE};
          default: return {junk[63:32], 32'h0000_0001};
        endcase
      end
      vc_pkg::TYPE_BYTE: begin
        case (k % 4)
          0: return {junk[63:8], 8'h00};
          1: return {junk[63:8], 8'hFF};
          2: return {junk[63:8], 8'h80};
          default: return {junk[63:8], 8'h7F};
        endcase
      end
      default: begin
        case (k % 10)
          0: return {junk[63:32], 32'h0000_0000};
          1: return {junk[63:32], 32'h3F80_0000};
          2: return {junk[63:32], 32'h7FC0_0000};
          3: return {junk[63:32], 32'h7F80_0000};
          4: return {junk[63:32], 32'hFF80_0000};
          5: return {junk[63:32], 32'hBF80_0000};
          6: return {junk[63:32], 32'h3F00_0000};
          7: return {junk[63:32], 32'h7F7F_FFFF};
          8: return {junk[63:32], 32'h3F7F_FFFF};
          default: return {junk[63:32], 32'h0000_0001};
        endcase
      end
    endcase
  endfunction

  // Random component: mostly values in the interesting range of the type,
  // some edge values, some raw noise over all 64 bits.
  function automatic logic [63:0] rand_component(logic [2:0] ty);
    int unsigned pick;
    logic [63:0] raw;
    pick = $urandom_range(0, 9);
    raw = {$urandom, $urandom};
    if (pick < 2) return raw;
    if (pick == 2) return edge_value(ty, $urandom_range(0, 9));
    case (ty)
      vc_pkg::TYPE_DOUBLE:
        return {($urandom_range(0, 7) == 0), 11'(1016 + $urandom_range(0, 8)), raw[51:0]};
      vc_pkg::TYPE_BYTE, vc_pkg::TYPE_U16, vc_pkg::TYPE_U32: return raw;
      default:
        return {raw[63:32], ($urandom_range(0, 7) == 0), 8'(119 + $urandom_range(0, 8)),
                raw[22:0]};
    endcase
  endfunction

  initial begin
    colour_in_t  c;
    logic [2:0]  dir_types[5];
    // Settings per random phase: enable, type, layout. Includes the unused
    // type and layout codes and a disabled phase.
    logic [5:0]  phases[15];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = vc_pkg::REG_ENABLE;
    cfg_data_i = 3'd0;
    colour_ch.valid = 1'b0;
    colour_ch.data = '0;
    cycles = 0;
    sent = 0;
    no_idle = 1'b0;
    sb = new();
    dir_types = '{vc_pkg::TYPE_FLOAT, vc_pkg::TYPE_DOUBLE, vc_pkg::TYPE_U16,
                  vc_pkg::TYPE_U32, vc_pkg::TYPE_BYTE};
    phases = '{{1'b1, vc_pkg::TYPE_FLOAT, vc_pkg::LAYOUT_RGBA},
               {1'b1, vc_pkg::TYPE_DOUBLE, vc_pkg::LAYOUT_RGBA},
               {1'b1, vc_pkg::TYPE_BYTE, vc_pkg::LAYOUT_RGBA},
               {1'b1, vc_pkg::TYPE_U16, vc_pkg::LAYOUT_RGBA},
               {1'b1, vc_pkg::TYPE_U32, vc_pkg::LAYOUT_RGBA},
               {1'b1, vc_pkg::TYPE_FLOAT, vc_pkg::LAYOUT_RGB},
               {1'b1, vc_pkg::TYPE_DOUBLE, LAYOUT_LANES},
               {1'b1, vc_pkg::TYPE_U16, vc_pkg::LAYOUT_RGB},
               {1'b1, vc_pkg::TYPE_U32, LAYOUT_LANES},
               {1'b1, 3'd5, 2'd3},
               {1'b1, 3'd7, vc_pkg::LAYOUT_RGB},
               {1'b1, vc_pkg::TYPE_BYTE, LAYOUT_LANES},
               {1'b0, vc_pkg::TYPE_U32, vc_pkg::LAYOUT_RGB},
               {1'b1, 3'd6, vc_pkg::LAYOUT_RGBA},
               {1'b1, vc_pkg::TYPE_DOUBLE, vc_pkg::LAYOUT_RGB}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: disabled, so a few words must come out all ones.
    for (int k = 0; k < 3; k++) begin
      c = {rand_component(vc_pkg::TYPE_FLOAT), rand_component(vc_pkg::TYPE_FLOAT),
           rand_component(vc_pkg::TYPE_FLOAT), rand_component(vc_pkg::TYPE_FLOAT)};
      send_colour(c);
    end

    // Directed: walk the edge values of each type through all four lanes.
    for (int t = 0; t < 5; t++) begin
      write_settings(1'b1, dir_types[t], vc_pkg::LAYOUT_RGBA);
      for (int k = 0; k < 4; k++) begin
        c.comp_a = edge_value(dir_types[t], 4 * k);
        c.comp_b = edge_value(dir_types[t], 4 * k + 1);
        c.comp_c = edge_value(dir_types[t], 4 * k + 2);
        c.comp_d = edge_value(dir_types[t], 4 * k + 3);
        send_colour(c);
      end
    end

    // Random phases; every third one runs without any idling on either side.
    for (int p = 0; p < 15; p++) begin
      write_settings(phases[p][5], phases[p][4:2], phases[p][1:0]);
      no_idle = (p % 3 == 2);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        c = {rand_component(sb.comp_type), rand_component(sb.comp_type),
             rand_component(sb.comp_type), rand_component(sb.comp_type)};
        send_colour(c);
      end
    end

    colour_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d colours over 15 random settings and all five types; %0d words checked.",
             sent, sb.checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
